[rtl/tmc_pkg.sv]
// shared constants and types for the two-means clustering unit
package tmc_pkg;
   localparam int MAX_POINTS  = 64;
   localparam int CACHE_SLOTS = 16;
   localparam int COORD_BITS  = 10;
   localparam int FRAC_BITS   = 8;
   localparam int MEAN_BITS   = COORD_BITS + FRAC_BITS;
   localparam int IDX_BITS    = $clog2(MAX_POINTS);
   localparam int CNT_BITS    = IDX_BITS + 1;
   localparam int SLOT_BITS   = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
   localparam int SUM_BITS    = COORD_BITS + IDX_BITS;
   localparam int DIV_BITS    = SUM_BITS + FRAC_BITS;
   localparam int DIST_BITS   = 2 * MEAN_BITS + 1;
   localparam int ITER_BITS   = 4;

   localparam logic [0:0] CSR_REUSE = 1'd0;
   localparam logic [0:0] CSR_ITER  = 1'd1;
   localparam logic [ITER_BITS-1:0] ITER_RESET = 4'd10;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [MEAN_BITS-1:0]  mean_type;

   // divider request and reply
   typedef struct packed {
      logic                go;
      logic [DIV_BITS-1:0] dividend;
      logic [CNT_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quotient;
   } div_rsp_type;
endpackage

[rtl/two_means_clustering_unit.sv]
// top level: point store, sequencer and shared distance unit
//
// channel   direction  handshake            word
// req_      in         start / busy         one point
// rsp_      out        rsp_valid strobe     one result per stored point
// csr_      in         csr_valid/csr_ready  register index and data
//
// a point that is not last is stored while idle. the last point starts clustering:
// memory read lead and mean setup, then per pass 2 mean fixups, each point through
// the shared square/add unit (read, mean 0 distance, mean 1 distance), then 4
// divisions. a cache write, then results stream one per cycle. reset is
// synchronous, active high; stores come up unwritten.
// the receiver cannot stall the results.
module two_means_clustering_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tmc_pkg::COORD_BITS-1:0]    req_coord_x,
   input  logic [tmc_pkg::COORD_BITS-1:0]    req_coord_y,
   input  logic [3:0]                        req_group_key,
   input  logic                              req_last_point,
   output logic                              rsp_valid,
   output logic [5:0]                        rsp_point_index,
   output logic                              rsp_cluster,
   output logic [tmc_pkg::MEAN_BITS-1:0]     rsp_mean0_x,
   output logic [tmc_pkg::MEAN_BITS-1:0]     rsp_mean0_y,
   output logic [tmc_pkg::MEAN_BITS-1:0]     rsp_mean1_x,
   output logic [tmc_pkg::MEAN_BITS-1:0]     rsp_mean1_y,
   output logic                              rsp_overflow,
   output logic                              rsp_last_result,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [0:0]                        csr_index,
   input  logic [3:0]                        csr_data
);
   import tmc_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_FIX   = 4'd2;
   localparam logic [3:0] S_READ  = 4'd3;
   localparam logic [3:0] S_DA    = 4'd4;
   localparam logic [3:0] S_DB    = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_DWAIT = 4'd7;
   localparam logic [3:0] S_OREAD = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;
   localparam logic [3:0] S_LOAD  = 4'd10;

   // stores
   logic [2*COORD_BITS-1:0] pmem [MAX_POINTS];
   logic                    amem [MAX_POINTS];
   logic [4*MEAN_BITS-1:0]  cmem [CACHE_SLOTS];
   logic [CACHE_SLOTS-1:0]  cvalid_ff;
   logic [2*COORD_BITS-1:0] prd_ff;
   logic                    ard_ff;
   logic [4*MEAN_BITS-1:0]  crd_ff;

   logic [3:0]           state_ff, state_in;
   logic [CNT_BITS-1:0]  count_ff;
   logic                 ovf_ff;
   logic                 reuse_ff;
   logic [ITER_BITS-1:0] iter_ff, pass_ff;
   logic [SLOT_BITS-1:0] slot_ff;
   logic [IDX_BITS-1:0]  idx_ff;
   logic [1:0]           sel_ff;
   logic                 fixc_ff;
   mean_type             mean_ff [4];
   logic [SUM_BITS-1:0]  sum_ff [4];
   logic [CNT_BITS-1:0]  cnt_ff [2];
   coord_type            first_x_ff, first_y_ff;
   logic [DIST_BITS-1:0] d0_ff;
   logic                 rv_ff, rlast_ff;
   logic [IDX_BITS-1:0]  ridx_ff;
   logic                 rcl_ff;
   logic                 rovf_ff;

   div_req_type dreq;
   div_rsp_type drsp;

   logic [SLOT_BITS-1:0]   key_slot;
   logic                   accept, is_last_idx, out_last;
   coord_type              px, py;
   mean_type               ma, mb, pa, pb, da, db;
   logic [2*MEAN_BITS-1:0] sqa, sqb;
   logic [DIST_BITS-1:0]   dsum;
   logic                   near1;

   assign key_slot = SLOT_BITS'(32'(req_group_key) % CACHE_SLOTS);
   assign accept   = start && !busy;
   assign busy     = (state_ff != S_IDLE);
   assign csr_ready = !busy;
   assign px = prd_ff[2*COORD_BITS-1:COORD_BITS];
   assign py = prd_ff[COORD_BITS-1:0];
   assign is_last_idx = ({1'b0, idx_ff} == count_ff - 1'b1);
   // output index runs one ahead of the word being registered
   assign out_last = (idx_ff == count_ff[IDX_BITS-1:0]);

   // shared distance unit: one mean per cycle, x and y squares summed
   always_comb begin
      ma = (state_ff == S_DA) ? mean_ff[0] : mean_ff[2];
      mb = (state_ff == S_DA) ? mean_ff[1] : mean_ff[3];
      pa = {px, FRAC_BITS'(0)};
      pb = {py, FRAC_BITS'(0)};
      da = (pa >= ma) ? pa - ma : ma - pa;
      db = (pb >= mb) ? pb - mb : mb - pb;
      sqa = da * da;
      sqb = db * db;
      dsum = {1'b0, sqa} + {1'b0, sqb};
      near1 = dsum < d0_ff;
   end

   // divider feed: sums of one coordinate over the cluster count, or over one when empty
   always_comb begin
      dreq.go       = (state_ff == S_DIV);
      dreq.dividend = {sum_ff[sel_ff], FRAC_BITS'(0)};
      dreq.divisor  = (cnt_ff[sel_ff[1]] == '0) ? CNT_BITS'(1) : cnt_ff[sel_ff[1]];
   end

   tmc_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept && req_last_point) state_in = S_LOAD;
         S_LOAD:  state_in = S_INIT;
         S_INIT:  state_in = S_FIX;
         S_FIX:   if (fixc_ff) state_in = S_READ;
         S_READ:  state_in = S_DA;
         S_DA:    state_in = S_DB;
         S_DB:    state_in = is_last_idx ? S_DIV : S_READ;
         S_DIV:   state_in = S_DWAIT;
         S_DWAIT: if (drsp.done)
                     state_in = (sel_ff != 2'd3) ? S_DIV :
                                (pass_ff == ITER_BITS'(1)) ? S_OREAD : S_FIX;
         S_OREAD: state_in = S_OUT;
         S_OUT:   if (out_last) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         reuse_ff  <= 1'b0;
         iter_ff   <= ITER_RESET;
         cvalid_ff <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= 1'b0;
         // configuration writes
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_REUSE) reuse_ff <= csr_data[0];
            else if (csr_index == CSR_ITER) iter_ff <= csr_data;
         end
         // load points
         if (accept) begin
            if (count_ff < CNT_BITS'(MAX_POINTS)) count_ff <= count_ff + 1'b1;
            else ovf_ff <= 1'b1;
         end
         if (state_ff == S_OREAD) cvalid_ff[slot_ff] <= 1'b1;
         if (state_ff == S_OUT) begin
            rv_ff <= 1'b1;
            if (out_last) begin
               count_ff <= '0;
               ovf_ff   <= 1'b0;
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prd_ff <= pmem[idx_ff];
      ard_ff <= amem[idx_ff];
      crd_ff <= cmem[slot_ff];
      if (accept && count_ff < CNT_BITS'(MAX_POINTS)) begin
         pmem[count_ff[IDX_BITS-1:0]] <= {req_coord_x, req_coord_y};
         if (count_ff == '0) begin
            first_x_ff <= req_coord_x;
            first_y_ff <= req_coord_y;
         end
      end
      case (state_ff)
         S_IDLE: if (accept && req_last_point) begin
            slot_ff <= key_slot;
            pass_ff <= (iter_ff == '0) ? ITER_BITS'(1) : iter_ff;
            // last stored point: this one, or point MAX_POINTS-1 when this one is dropped
            idx_ff  <= (count_ff < CNT_BITS'(MAX_POINTS)) ? count_ff[IDX_BITS-1:0]
                                                          : IDX_BITS'(MAX_POINTS - 1);
         end
         S_INIT: begin
            if (reuse_ff && cvalid_ff[slot_ff]) begin
               mean_ff[0] <= crd_ff[4*MEAN_BITS-1:3*MEAN_BITS];
               mean_ff[1] <= crd_ff[3*MEAN_BITS-1:2*MEAN_BITS];
               mean_ff[2] <= crd_ff[2*MEAN_BITS-1:MEAN_BITS];
               mean_ff[3] <= crd_ff[MEAN_BITS-1:0];
            end else begin
               mean_ff[0] <= {first_x_ff, FRAC_BITS'(0)};
               mean_ff[1] <= {first_y_ff, FRAC_BITS'(0)};
               mean_ff[2] <= {px, FRAC_BITS'(0)};
               mean_ff[3] <= {py, FRAC_BITS'(0)};
            end
            fixc_ff <= 1'b0;
         end
         // replace an all-zero mean by the first point, one mean per cycle; clear sums and counts
         S_FIX: begin
            if (mean_ff[{fixc_ff, 1'b0}] == '0 && mean_ff[{fixc_ff, 1'b1}] == '0) begin
               mean_ff[{fixc_ff, 1'b0}] <= {first_x_ff, FRAC_BITS'(0)};
               mean_ff[{fixc_ff, 1'b1}] <= {first_y_ff, FRAC_BITS'(0)};
            end
            fixc_ff <= ~fixc_ff;
            idx_ff  <= '0;
            for (int k = 0; k < 4; k++) sum_ff[k] <= '0;
            cnt_ff[0] <= '0;
            cnt_ff[1] <= '0;
         end
         S_DA: d0_ff <= dsum;
         S_DB: begin
            amem[idx_ff] <= near1;
            sum_ff[{near1, 1'b0}] <= sum_ff[{near1, 1'b0}] + SUM_BITS'(px);
            sum_ff[{near1, 1'b1}] <= sum_ff[{near1, 1'b1}] + SUM_BITS'(py);
            cnt_ff[near1] <= cnt_ff[near1] + 1'b1;
            if (is_last_idx) sel_ff <= 2'd0;
            else idx_ff <= idx_ff + 1'b1;
         end
         S_DWAIT: if (drsp.done) begin
            mean_ff[sel_ff] <= MEAN_BITS'(drsp.quotient);
            sel_ff <= sel_ff + 1'b1;
            if (sel_ff == 2'd3) begin
               pass_ff <= pass_ff - 1'b1;
               idx_ff  <= '0;
               fixc_ff <= 1'b0;
            end
         end
         S_OREAD: begin
            cmem[slot_ff] <= {mean_ff[0], mean_ff[1], mean_ff[2], mean_ff[3]};
            idx_ff <= idx_ff + 1'b1;
         end
         S_OUT: begin
            ridx_ff  <= idx_ff - 1'b1;
            rcl_ff   <= ard_ff;
            rlast_ff <= out_last;
            rovf_ff  <= ovf_ff;
            idx_ff   <= idx_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_valid       = rv_ff;
   assign rsp_point_index = 6'(ridx_ff);
   assign rsp_cluster     = rcl_ff;
   assign rsp_mean0_x     = mean_ff[0];
   assign rsp_mean0_y     = mean_ff[1];
   assign rsp_mean1_x     = mean_ff[2];
   assign rsp_mean1_y     = mean_ff[3];
   assign rsp_overflow    = rovf_ff;
   assign rsp_last_result = rlast_ff;
endmodule

[rtl/tmc_divider.sv]
// restoring divider, one quotient bit per cycle
module tmc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  tmc_pkg::div_req_type req,
   output tmc_pkg::div_rsp_type rsp
);
   import tmc_pkg::*;

   localparam int STEP_BITS = $clog2(DIV_BITS + 1);

   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic [CNT_BITS:0]    rem_ff, rem_in;
   logic [CNT_BITS-1:0]  den_ff, den_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 run_ff, run_in, done_ff, done_in;
   logic [CNT_BITS:0]    trial;

   // one shift and compare per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[CNT_BITS-1:0], quo_ff[DIV_BITS-1]};
      if (req.go) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         step_in = STEP_BITS'(DIV_BITS);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

[rtl/tmc_checker.sv]
// port-level checks for the two-means clustering unit
module tmc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last_point,
   input logic rsp_valid,
   input logic rsp_last_result,
   input logic csr_ready
);
   // a last point always makes the block busy
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_point |=> busy) else $error("last point not taken");
   // results only come while busy or right at its end
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy || $past(busy)) else $error("result while idle");
   // block is already idle when the final result appears
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |-> !busy) else $error("busy after final result");
   // configuration is closed while busy
   a_csr: assert property (@(posedge clock) disable iff (reset)
      busy |-> !csr_ready) else $error("config open while busy");
endmodule

bind two_means_clustering_unit tmc_checker u_tmc_checker (.*);
